// File: design/keyframe_linear_sampler_macros.svh
// Assertion macros shared by the keyframe sampler checkers.
// No dependencies; included by files that assert.
`ifndef KEYFRAME_LINEAR_SAMPLER_MACROS_SVH
`define KEYFRAME_LINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define KLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define KLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kls_pkg.sv
// Types and constants for the keyframe linear sampler.
// No dependencies; used by the keystore, the sampler and the checker.
package kls_pkg;

    localparam int MAX_KEYS = 64;
    localparam int AW       = $clog2(MAX_KEYS);
    localparam int CW       = $clog2(MAX_KEYS + 1);
    localparam int QW       = 17;                    // fraction 0..65536
    localparam int DIV_LAST = QW - 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_SAMPLE  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DONE    = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        t_op                operation;
        logic [31:0]        key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0]        sample_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic [31:0] key_time;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_key;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        t_key          key;
    } t_wr;

endpackage

// File: design/kls_keystore.sv
// Keyframe store: one write port, one read port with registered data.
// Depends on kls_pkg.
module kls_keystore (
    input  logic                  i_clk,
    input  kls_pkg::t_wr          i_wr,
    input  logic [kls_pkg::AW-1:0] i_rd_addr,
    output kls_pkg::t_key         o_rd_key
);

    kls_pkg::t_key r_mem [kls_pkg::MAX_KEYS];
    kls_pkg::t_key r_rd_key;

    // Write appended keys
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.key;
        end
    end

    // Read every cycle
    always_ff @(posedge i_clk) begin
        r_rd_key <= r_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;

endmodule

// File: design/keyframe_linear_sampler.sv
// Keyframe linear sampler: holds one xyz curve of up to MAX_KEYS keys and
// samples it by piecewise linear interpolation, one word in and one word out
// per operation. The block takes one word at a time and is stalled until its
// result is loaded into the output register. Clear, append and the reserved
// operation go straight to the output stage, as does a sample on an empty curve;
// one at or beyond either end first fetches that end key. An interior sample
// takes the word and presents key 0, scans through the single key store read
// port to the key that ends its segment, runs the one-bit-per-cycle divider for
// the 16-bit fraction, uses the shared multiplier and adder in turn for x, y, z,
// and loads the result. A previous result still waiting in the output register
// holds off the load.
// Depends on kls_pkg and kls_keystore.
module keyframe_linear_sampler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kls_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kls_pkg::t_out o_out
);

    kls_pkg::t_state            r_state, n_state;
    logic [kls_pkg::CW-1:0]     r_count, n_count;
    logic [31:0]                r_first_time, n_first_time;
    logic [31:0]                r_last_time, n_last_time;
    logic [31:0]                r_time, n_time;
    logic [kls_pkg::AW-1:0]     r_addr, n_addr;
    kls_pkg::t_key              r_prev, n_prev;
    kls_pkg::t_key              r_cur, n_cur;
    logic [32:0]                r_rem, n_rem;
    logic [31:0]                r_div, n_div;
    logic [kls_pkg::QW-1:0]     r_q, n_q;
    logic [4:0]                 r_step, n_step;
    logic [1:0]                 r_comp, n_comp;
    logic signed [50:0]         r_prod, n_prod;
    kls_pkg::t_out              r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    kls_pkg::t_out              r_out, n_out;

    kls_pkg::t_wr               w_wr;
    logic [kls_pkg::AW-1:0]     w_rd_addr;
    kls_pkg::t_key              w_rd_key;
    logic                       w_accept;
    logic                       w_empty;
    logic                       w_full;
    logic                       w_at_first;
    logic                       w_at_last;
    logic                       w_append_ok;
    logic [kls_pkg::CW-1:0]     w_last_idx;
    logic                       w_found;
    logic                       w_out_load;
    logic [33:0]                w_trial;
    logic                       w_ge;
    logic [31:0]                w_v0, w_v1;
    logic signed [32:0]         w_diff;
    logic signed [17:0]         w_frac;
    logic [31:0]                w_sum;

    kls_keystore u_keystore (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key)
    );

    // Decode the incoming word against the stored curve
    assign w_accept    = i_in_valid && (r_state == kls_pkg::S_IDLE);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == kls_pkg::CW'(kls_pkg::MAX_KEYS));
    assign w_at_first  = (i_in.sample_time <= r_first_time);
    assign w_at_last   = (i_in.sample_time >= r_last_time);
    assign w_append_ok = !w_full && (w_empty || (i_in.key_time >= r_last_time));
    assign w_last_idx  = r_count - kls_pkg::CW'(1);
    assign w_found     = (r_time <= w_rd_key.key_time);
    assign w_out_load  = !r_out_valid || !i_out_stall;

    // Divider step: one quotient bit per cycle
    assign w_trial = {1'b0, r_rem} - {2'b00, r_div};
    assign w_ge    = !w_trial[33];

    // Shared multiplier and adder operands
    always_comb begin
        case (r_comp)
            kls_pkg::COMP_X: begin
                w_v0 = r_prev.x;
                w_v1 = r_cur.x;
            end
            kls_pkg::COMP_Y: begin
                w_v0 = r_prev.y;
                w_v1 = r_cur.y;
            end
            kls_pkg::COMP_Z: begin
                w_v0 = r_prev.z;
                w_v1 = r_cur.z;
            end
            default: begin
                w_v0 = r_prev.x;
                w_v1 = r_cur.x;
            end
        endcase
    end

    assign w_diff = $signed({w_v1[31], w_v1}) - $signed({w_v0[31], w_v0});
    assign w_frac = $signed({1'b0, r_q});
    // Floor of product / 65536, low 32 bits
    assign w_sum  = w_v0 + r_prod[47:16];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kls_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in.operation == kls_pkg::OP_SAMPLE && !w_empty) begin
                        if (w_at_first || w_at_last) begin
                            n_state = kls_pkg::S_FETCH;
                        end else begin
                            n_state = kls_pkg::S_SCAN;
                        end
                    end else begin
                        n_state = kls_pkg::S_OUT;
                    end
                end
            end
            kls_pkg::S_FETCH: begin
                n_state = kls_pkg::S_OUT;
            end
            kls_pkg::S_SCAN: begin
                if (w_found) begin
                    n_state = kls_pkg::S_DIV;
                end
            end
            kls_pkg::S_DIV: begin
                if (r_step == 5'(kls_pkg::DIV_LAST)) begin
                    n_state = kls_pkg::S_MUL;
                end
            end
            kls_pkg::S_MUL: begin
                n_state = kls_pkg::S_ACC;
            end
            kls_pkg::S_ACC: begin
                if (r_comp == kls_pkg::COMP_Z) begin
                    n_state = kls_pkg::S_OUT;
                end else begin
                    n_state = kls_pkg::S_MUL;
                end
            end
            kls_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = kls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kls_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and key store controls
    always_comb begin
        o_in_stall  = (r_state != kls_pkg::S_IDLE);
        w_wr.en     = w_accept && (i_in.operation == kls_pkg::OP_APPEND) && w_append_ok;
        w_wr.addr   = r_count[kls_pkg::AW-1:0];
        w_wr.key    = '{key_time: i_in.key_time, x: i_in.value_x,
                        y: i_in.value_y, z: i_in.value_z};
        w_rd_addr   = r_addr;
        if (r_state == kls_pkg::S_IDLE) begin
            if (w_at_last && !w_at_first) begin
                w_rd_addr = w_last_idx[kls_pkg::AW-1:0];
            end else begin
                w_rd_addr = '0;
            end
        end
    end

    // Datapath next values
    always_comb begin
        n_count      = r_count;
        n_first_time = r_first_time;
        n_last_time  = r_last_time;
        n_time       = r_time;
        n_addr       = r_addr;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_rem        = r_rem;
        n_div        = r_div;
        n_q          = r_q;
        n_step       = r_step;
        n_comp       = r_comp;
        n_prod       = r_prod;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;

        // Drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            kls_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_time = i_in.sample_time;
                    n_addr = kls_pkg::AW'(1);
                    n_res  = '{out_x: '0, out_y: '0, out_z: '0,
                               status: kls_pkg::ST_REFUSED};
                    case (i_in.operation)
                        kls_pkg::OP_CLEAR: begin
                            n_count      = '0;
                            n_res.status = kls_pkg::ST_DONE;
                        end
                        kls_pkg::OP_APPEND: begin
                            if (w_append_ok) begin
                                n_count      = r_count + kls_pkg::CW'(1);
                                n_last_time  = i_in.key_time;
                                n_res.status = kls_pkg::ST_DONE;
                                if (w_empty) begin
                                    n_first_time = i_in.key_time;
                                end
                            end
                        end
                        kls_pkg::OP_SAMPLE: begin
                            if (w_empty) begin
                                n_res.status = kls_pkg::ST_EMPTY;
                            end else begin
                                n_res.status = kls_pkg::ST_SAMPLE;
                            end
                        end
                        default: begin
                            n_res.status = kls_pkg::ST_REFUSED;
                        end
                    endcase
                end
            end
            kls_pkg::S_FETCH: begin
                n_res.out_x = w_rd_key.x;
                n_res.out_y = w_rd_key.y;
                n_res.out_z = w_rd_key.z;
            end
            kls_pkg::S_SCAN: begin
                // Advance until the time falls at or below a key
                n_addr = r_addr + kls_pkg::AW'(1);
                if (w_found) begin
                    n_cur  = w_rd_key;
                    n_rem  = {1'b0, r_time - r_prev.key_time};
                    n_div  = w_rd_key.key_time - r_prev.key_time;
                    n_q    = '0;
                    n_step = '0;
                end else begin
                    n_prev = w_rd_key;
                end
            end
            kls_pkg::S_DIV: begin
                n_q    = {r_q[kls_pkg::QW-2:0], w_ge};
                n_rem  = {(w_ge ? w_trial[31:0] : r_rem[31:0]), 1'b0};
                n_step = r_step + 5'd1;
                n_comp = kls_pkg::COMP_X;
            end
            kls_pkg::S_MUL: begin
                n_prod = 51'(w_diff) * 51'(w_frac);
            end
            kls_pkg::S_ACC: begin
                n_comp = r_comp + 2'd1;
                case (r_comp)
                    kls_pkg::COMP_X: n_res.out_x = w_sum;
                    kls_pkg::COMP_Y: n_res.out_y = w_sum;
                    kls_pkg::COMP_Z: n_res.out_z = w_sum;
                    default:         n_res.out_x = r_res.out_x;
                endcase
            end
            kls_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kls_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_first_time <= n_first_time;
        r_last_time  <= n_last_time;
        r_time       <= n_time;
        r_addr       <= n_addr;
        r_prev       <= n_prev;
        r_cur        <= n_cur;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_q          <= n_q;
        r_step       <= n_step;
        r_comp       <= n_comp;
        r_prod       <= n_prod;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: design/kls_checker.sv
// Port-level checks for the keyframe linear sampler, bound to the top level.
// Depends on kls_pkg and keyframe_linear_sampler_macros.svh.
`include "keyframe_linear_sampler_macros.svh"

module kls_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input kls_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input kls_pkg::t_out o_out
);

    // Held output word keeps its payload
    `KLS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "output word changed while stalled")

    // Block goes busy after taking a word
    `KLS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

    // A new result only appears while the input side is held off
    `KLS_ASSERT_IMP(a_result_while_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without an item in flight")

    // Non-sample results carry zero values
    `KLS_ASSERT_IMP(a_zero_values, i_clk, i_rst_n, o_out_valid && (o_out.status != kls_pkg::ST_SAMPLE), (o_out.out_x == 0) && (o_out.out_y == 0) && (o_out.out_z == 0), "nonzero values on a non-sample result")

endmodule

bind keyframe_linear_sampler kls_checker u_kls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
